// ----- design/chcavg_pkg.sv -----
// Shared constants, types and the CORDIC arctangent table for the compass heading averager.
`default_nettype none

package chcavg_pkg;

  // Sample and calibration widths.
  localparam int SAMPLE_W = 12;
  localparam int SAMPLES_PER_HEADING = 10;
  localparam int CORDIC_ITERATIONS = 16;

  // Accumulator and sample counter.
  localparam int SUM_W = $clog2(SAMPLES_PER_HEADING * 2048) + 1;
  localparam int CNT_W = (SAMPLES_PER_HEADING > 1) ? $clog2(SAMPLES_PER_HEADING) : 1;

  // Scaling: numerator 2*sum - N*(max+min), denominator N*(max-min).
  localparam int NUM_W = SUM_W + 2;
  localparam int DEN_W = SUM_W + 1;
  localparam int DVD_W = NUM_W + 16;
  localparam int DIV_W = DEN_W + 1;

  // Scaled axis in Q3.15.
  localparam int Q_W = 18;
  localparam logic [Q_W-1:0] Q_POS_MAX = 18'd131071;
  localparam logic [Q_W-1:0] Q_NEG_MAX = 18'd131072;

  // CORDIC datapath.
  localparam int CW = Q_W + 3;
  localparam int ANG_W = 32;
  localparam int ITER_W = 5;
  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
  localparam logic [ANG_W-1:0] ANG_HALF_TURN = 32'h8000_0000;

  // Binary angle to centidegrees.
  localparam int PROD_W = 48;
  localparam int HEAD_W = 16;
  localparam logic [HEAD_W-1:0] CDEG_TURN = 16'd36000;
  localparam logic [PROD_W-1:0] CONV_ROUND = 48'h0000_8000_0000;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] RST_MIN_X = -12'sd221;
  localparam logic signed [SAMPLE_W-1:0] RST_MAX_X = -12'sd64;
  localparam logic signed [SAMPLE_W-1:0] RST_MIN_Y = -12'sd118;
  localparam logic signed [SAMPLE_W-1:0] RST_MAX_Y = 12'sd70;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CORDIC_START,
    ST_CORDIC_WAIT,
    ST_CONV_MUL,
    ST_CONV_RND
  } state_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 = 360 degrees.
  function automatic logic [ANG_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [ANG_W-1:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- design/compass_heading_averager_core.sv -----
// Top level of the compass heading averager: sample accumulator, sequencer and output register.
`default_nettype none

// Sums raw X/Y magnetometer samples and, after every SAMPLES_PER_HEADING transfers, turns
// the two sums into one heading in centidegrees (0..35999). Each axis is mapped with the
// min/max calibration registers to about [-1,1] in Q3.15 (rounded, saturated), then a
// 16-step vectoring CORDIC gives atan2(y, x). A sample that does not close a group is
// taken with s_tready staying high. The sample that closes a group occupies the block,
// with s_tready low throughout, for two passes of the serial divider (DVD_W = 34 quotient
// steps plus load, start and done), the CORDIC (start, 16 steps, done) and an
// angle-to-centidegree conversion (multiply, then round). When both scaled axes are zero
// the CORDIC finishes at once. The heading is valid in the cycle after the round step.
// If max equals min on either axis the result is heading 0 with calib_error set, delivered
// in the cycle after the closing transfer. The result waits in an output register; samples
// keep being taken while it waits, but the sample that closes the next group is held off
// until the pending result is taken. Configuration writes are always accepted (cfg_ready is
// tied high) and are meant for idle periods only.
module compass_heading_averager_core
  import chcavg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_W-1:0]  cfg_data,
  // Sample stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [23:0]          s_tdata,   // [11:0] mag_x, [23:12] mag_y
  // Heading stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [HEAD_W-1:0]         m_tdata,   // [15:0] heading_cdeg
  output logic [0:0]                m_tuser    // [0] calib_error
);

  // Calibration registers
  logic signed [SAMPLE_W-1:0] min_x;
  logic signed [SAMPLE_W-1:0] max_x;
  logic signed [SAMPLE_W-1:0] min_y;
  logic signed [SAMPLE_W-1:0] max_y;

  // Accumulator
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [CNT_W-1:0]        sample_count;

  // Sequencer
  state_t state;
  state_t state_next;
  logic   axis;
  logic   div_start;
  logic   cordic_start;

  // Scaling datapath
  logic signed [NUM_W-1:0] num;
  logic signed [DEN_W-1:0] den;
  logic                    neg;
  logic signed [Q_W-1:0]   sx;
  logic signed [Q_W-1:0]   sy;

  logic [PROD_W-1:0]       prod;

  logic signed [SAMPLE_W-1:0] mag_x;
  logic signed [SAMPLE_W-1:0] mag_y;
  logic                       s_xfer;
  logic                       last;
  logic                       bad_calib;

  logic signed [SUM_W-1:0]    sum_sel;
  logic signed [SAMPLE_W-1:0] lo_sel;
  logic signed [SAMPLE_W-1:0] hi_sel;
  logic signed [SAMPLE_W:0]   hl_sum;
  logic signed [SAMPLE_W:0]   hl_dif;
  logic signed [NUM_W-1:0]    num_calc;
  logic signed [DEN_W-1:0]    den_calc;

  logic [NUM_W-1:0] an;
  logic [DEN_W-1:0] ad;
  logic [DVD_W-1:0] dividend;
  logic [DIV_W-1:0] divisor;
  logic             div_done;
  logic [DVD_W-1:0] quotient;
  logic [Q_W-1:0]   q_mag;
  logic signed [Q_W-1:0] q_signed;

  logic             cordic_done;
  logic [ANG_W-1:0] angle;
  logic [PROD_W-1:0] rnd;
  logic [HEAD_W-1:0] cdeg;

  localparam logic signed [NUM_W-1:0] N_NUM = NUM_W'(SAMPLES_PER_HEADING);
  localparam logic signed [DEN_W-1:0] N_DEN = DEN_W'(SAMPLES_PER_HEADING);

  assign mag_x     = s_tdata[11:0];
  assign mag_y     = s_tdata[23:12];
  assign cfg_ready = 1'b1;
  assign s_xfer    = s_tvalid & s_tready;
  assign last      = (sample_count == CNT_W'(SAMPLES_PER_HEADING - 1));
  assign bad_calib = (max_x == min_x) || (max_y == min_y);

  // Hold off the closing sample while a previous result still waits at the output.
  assign s_tready = (state == ST_IDLE) && !(last && m_tvalid);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= RST_MIN_X;
      max_x <= RST_MAX_X;
      min_y <= RST_MIN_Y;
      max_y <= RST_MAX_Y;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_X: min_x <= cfg_data;
        REG_MAX_X: max_x <= cfg_data;
        REG_MIN_Y: min_y <= cfg_data;
        REG_MAX_Y: max_y <= cfg_data;
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Axis scaling: numerator and denominator for the selected axis
  // ---------------------------------------------------------------------------
  always_comb begin
    sum_sel  = axis ? sum_y : sum_x;
    lo_sel   = axis ? min_y : min_x;
    hi_sel   = axis ? max_y : max_x;
    hl_sum   = (SAMPLE_W + 1)'(hi_sel) + (SAMPLE_W + 1)'(lo_sel);
    hl_dif   = (SAMPLE_W + 1)'(hi_sel) - (SAMPLE_W + 1)'(lo_sel);
    num_calc = (NUM_W'(sum_sel) <<< 1) - N_NUM * NUM_W'(hl_sum);
    den_calc = N_DEN * DEN_W'(hl_dif);
  end

  // Magnitudes feed the divider; the rounding half is folded into the dividend.
  always_comb begin
    an       = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    ad       = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    dividend = {an, 16'h0000} + DVD_W'(ad);
    divisor  = {ad, 1'b0};
  end

  // Saturate the quotient to Q3.15 and restore the sign.
  always_comb begin
    if (neg) begin
      q_mag = (quotient > DVD_W'(Q_NEG_MAX)) ? Q_NEG_MAX : quotient[Q_W-1:0];
    end else begin
      q_mag = (quotient > DVD_W'(Q_POS_MAX)) ? Q_POS_MAX : quotient[Q_W-1:0];
    end
    q_signed = neg ? -$signed(q_mag) : $signed(q_mag);
  end

  // Centidegrees: round the scaled angle, wrap a full turn to zero.
  always_comb begin
    rnd  = prod + CONV_ROUND;
    cdeg = rnd[PROD_W-1:32];
    if (cdeg >= CDEG_TURN) begin
      cdeg = '0;
    end
  end

  chcavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  chcavg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (sx),
    .y_in  (sy),
    .done  (cordic_done),
    .angle (angle)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    cordic_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_xfer && last && !bad_calib) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = axis ? ST_CORDIC_START : ST_PREP;
        end
      end
      ST_CORDIC_START: begin
        cordic_start = 1'b1;
        state_next   = ST_CORDIC_WAIT;
      end
      ST_CORDIC_WAIT: begin
        if (cordic_done) begin
          state_next = ST_CONV_MUL;
        end
      end
      ST_CONV_MUL: begin
        state_next = ST_CONV_RND;
      end
      ST_CONV_RND: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Accumulator, datapath registers and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x        <= '0;
      sum_y        <= '0;
      sample_count <= '0;
      axis         <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            axis <= 1'b0;
            if (last) begin
              sample_count <= '0;
              if (bad_calib) begin
                // Degenerate calibration: report the error and drop the sums.
                sum_x    <= '0;
                sum_y    <= '0;
                m_tvalid <= 1'b1;
              end else begin
                sum_x <= sum_x + SUM_W'(mag_x);
                sum_y <= sum_y + SUM_W'(mag_y);
              end
            end else begin
              sample_count <= sample_count + 1'b1;
              sum_x        <= sum_x + SUM_W'(mag_x);
              sum_y        <= sum_y + SUM_W'(mag_y);
            end
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            axis <= 1'b1;
          end
        end
        ST_CONV_RND: begin
          sum_x    <= '0;
          sum_y    <= '0;
          m_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      num <= num_calc;
      den <= den_calc;
    end
    if (state == ST_DIV_START) begin
      neg <= num[NUM_W-1] ^ den[DEN_W-1];
    end
    if (state == ST_DIV_WAIT && div_done) begin
      if (axis) begin
        sy <= q_signed;
      end else begin
        sx <= q_signed;
      end
    end
    if (state == ST_CONV_MUL) begin
      prod <= PROD_W'(angle) * PROD_W'(CDEG_TURN);
    end
    if (state == ST_IDLE && s_xfer && last && bad_calib) begin
      m_tdata    <= '0;
      m_tuser[0] <= 1'b1;
    end else if (state == ST_CONV_RND) begin
      m_tdata    <= cdeg;
      m_tuser[0] <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // A heading is always inside one turn.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata < CDEG_TURN))
    else $error("heading out of range");

  // A calibration error always carries heading zero.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("calibration error with nonzero heading");

  // The closing sample never arrives while a result is still pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && last) |-> !m_tvalid)
    else $error("closing sample taken while output pending");

  // The sample counter wraps at the group size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(SAMPLES_PER_HEADING - 1))
    else $error("sample counter past group size");
`endif

endmodule

`default_nettype wire

// ----- design/chcavg_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module chcavg_div
  import chcavg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int DCNT_W = $clog2(DVD_W);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsr;
  logic [DVD_W-1:0]  shreg;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              qbit;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem, shreg[DVD_W-1]};
    diff  = trial - {1'b0, dsr};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dsr   <= divisor;
      shreg <= dividend;
    end else if (busy) begin
      rem   <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      shreg <= {shreg[DVD_W-2:0], qbit};
    end
  end

  assign quotient = shreg;

endmodule

`default_nettype wire

// ----- design/chcavg_cordic.sv -----
// Vectoring CORDIC, one micro-rotation per cycle, giving a 32-bit binary angle.
`default_nettype none

module chcavg_cordic
  import chcavg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic signed [Q_W-1:0] x_in,
  input  wire logic signed [Q_W-1:0] y_in,
  output logic                       done,
  output logic             [ANG_W-1:0] angle
);

  logic                busy;
  logic [ITER_W-1:0]   it;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] x_ext;
  logic signed [CW-1:0] y_ext;

  assign x_ext = CW'(x_in);
  assign y_ext = CW'(y_in);
  assign dx    = y >>> it;
  assign dy    = x >>> it;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        it <= '0;
        // A zero vector has no direction: report angle zero at once.
        if (x_in == '0 && y_in == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        it <= it + 1'b1;
        if (it == ITER_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // Fold the left half plane over by half a turn.
      if (x_in < 0) begin
        x     <= -x_ext;
        y     <= -y_ext;
        angle <= ANG_HALF_TURN;
      end else begin
        x     <= x_ext;
        y     <= y_ext;
        angle <= '0;
      end
    end else if (busy) begin
      if (y < 0) begin
        x     <= x - dx;
        y     <= y + dy;
        angle <= angle - atan_turn(it);
      end else begin
        x     <= x + dx;
        y     <= y - dy;
        angle <= angle + atan_turn(it);
      end
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_compass_heading_averager_core.sv -----
// Self-checking testbench for compass_heading_averager_core: table-driven and random streams.
module tb_compass_heading_averager_core;
  import chcavg_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1000;
  // A closing sample keeps the block busy; leave margin.
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int TIMEOUT_CYCLES = 400000;

  // atan(2^-i) as a fraction of a full turn, 2^32 = 360 degrees.
  localparam bit [31:0] ATAN_TURN [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct {
    logic [HEAD_W-1:0] cdeg;
    logic              err;
  } heading_t;

  // One directed group: optional calibration, a sample held for a whole group, and
  // an expected heading where it is obvious without the arithmetic.
  typedef struct {
    bit do_cal;
    int lo_x, hi_x, lo_y, hi_y;
    int x, y;
    bit pinned;
    int cdeg;
    bit err;
  } group_row_t;

  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} ready_mode_e;
  typedef enum {SMP_NEAR, SMP_WIDE, SMP_EDGE, SMP_SPAN} sample_kind_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;    // [11:0] mag_x, [23:12] mag_y
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [HEAD_W-1:0]    m_tdata;         // [15:0] heading_cdeg
  logic [0:0]           m_tuser;         // [0] calib_error

  compass_heading_averager_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Predictor copy of the block: calibration, running sums and sample count.
  int       cal_min_x = int'(RST_MIN_X);
  int       cal_max_x = int'(RST_MAX_X);
  int       cal_min_y = int'(RST_MIN_Y);
  int       cal_max_y = int'(RST_MAX_Y);
  longint   acc_x = 0;
  longint   acc_y = 0;
  int       acc_count = 0;
  heading_t heading_q [$];

  // Pinned expectation for the next group, set by the directed table.
  bit       pin_valid = 1'b0;
  heading_t pin_want;

  // Run statistics.
  int fail_count = 0;
  int samples_taken = 0;
  int headings_seen = 0;
  int fault_headings = 0;
  int cal_phases = 0;
  int quad_hits [4] = '{0, 0, 0, 0};

  // Sender pacing and receiver hold-off request.
  int burst_left = 0;
  bit hold_req = 1'b0;
  int cal_plan [4];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int clip12(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic int rand12();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // Map one axis sum to Q3.15: (2*sum - N*(hi+lo)) / (N*(hi-lo)), round half away, saturate.
  function automatic longint scale_to_q15(input longint sum, input int lo, input int hi);
    longint num, den, an, ad, q;
    bit     neg;
    num = 2 * sum - longint'(SAMPLES_PER_HEADING) * (longint'(hi) + longint'(lo));
    den = longint'(SAMPLES_PER_HEADING) * (longint'(hi) - longint'(lo));
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an * 65536 + ad) / (2 * ad);
    if (neg) begin
      if (q > 131072) q = 131072;
      return -q;
    end
    if (q > 131071) q = 131071;
    return q;
  endfunction

  // Vectoring CORDIC on the scaled pair, angle as a binary turn, then centidegrees.
  function automatic int vector_heading_cdeg(input longint vx, input longint vy);
    bit [31:0] z;
    bit [63:0] cd;
    longint    dx, dy;
    int        i;
    z = '0;
    if (vx == 0 && vy == 0) return 0;
    // Left half plane: turn by half a turn first.
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      z = 32'h8000_0000;
    end
    for (i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy < 0) begin
        vx = vx - dx;
        vy = vy + dy;
        z = z - ATAN_TURN[i];
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        z = z + ATAN_TURN[i];
      end
    end
    cd = ({32'd0, z} * 64'd36000 + 64'h8000_0000) >> 32;
    if (cd >= 64'd36000) cd = '0;
    return int'(cd);
  endfunction

  function automatic heading_t predict_heading();
    heading_t h;
    h.err = (cal_max_x == cal_min_x) || (cal_max_y == cal_min_y);
    if (h.err) h.cdeg = '0;
    else h.cdeg = HEAD_W'(vector_heading_cdeg(scale_to_q15(acc_x, cal_min_x, cal_max_x),
                                               scale_to_q15(acc_y, cal_min_y, cal_max_y)));
    return h;
  endfunction

  // Observe every transfer at the clock edge: track calibration, accumulate samples,
  // queue a heading when a group closes and check headings as they leave the block.
  always @(posedge clk) begin : scoreboard
    heading_t want, got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_X: cal_min_x = int'($signed(cfg_data));
          REG_MAX_X: cal_max_x = int'($signed(cfg_data));
          REG_MIN_Y: cal_min_y = int'($signed(cfg_data));
          REG_MAX_Y: cal_max_y = int'($signed(cfg_data));
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        acc_x += $signed(s_tdata[11:0]);
        acc_y += $signed(s_tdata[23:12]);
        acc_count++;
        samples_taken++;
        if (acc_count == SAMPLES_PER_HEADING) begin
          if (pin_valid) begin
            want = pin_want;
            pin_valid = 1'b0;
          end else begin
            want = predict_heading();
          end
          heading_q.push_back(want);
          acc_x = 0;
          acc_y = 0;
          acc_count = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        got.cdeg = m_tdata;
        got.err = m_tuser[0];
        if (heading_q.size() == 0) begin
          report_mismatch("heading with none pending", got.cdeg, -1);
        end else begin
          want = heading_q.pop_front();
          if (got.cdeg !== want.cdeg) report_mismatch("heading_cdeg", got.cdeg, want.cdeg);
          if (got.err !== want.err) report_mismatch("calib_error", got.err, want.err);
          headings_seen++;
          if (want.err) fault_headings++;
          else if (want.cdeg < 36000) quad_hits[want.cdeg / 9000]++;
        end
      end
    end
  end

  // Receiver: switch between stall patterns; on request hold off for a long stretch.
  initial begin : result_sink
    ready_mode_e mode;
    int          dwell;
    int          tick;
    mode = RDY_ALWAYS;
    dwell = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        if (dwell == 0) begin
          mode = ready_mode_e'($urandom_range(0, 3));
          dwell = $urandom_range(50, 300);
        end
        dwell--;
        case (mode)
          RDY_ALWAYS:  m_tready <= 1'b1;
          RDY_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
          RDY_RARELY:  m_tready <= ($urandom_range(0, 3) == 0);
          default:     m_tready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // Write all four calibration registers, one transfer each; call only while idle.
  task automatic write_calibration(input int lo_x, input int hi_x, input int lo_y,
                                   input int hi_y);
    logic [CFG_IDX_W-1:0] idx [4];
    int                   val [4];
    int                   i;
    idx = '{REG_MIN_X, REG_MAX_X, REG_MIN_Y, REG_MAX_Y};
    val = '{lo_x, hi_x, lo_y, hi_y};
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= SAMPLE_W'(val[i]);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cal_phases++;
  endtask

  // Offer one sample; the sender runs in bursts with random gaps between them.
  task automatic offer_sample(input int x, input int y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {SAMPLE_W'(y), SAMPLE_W'(x)};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid, wait for every pending heading, then let the datapath settle.
  task automatic drain_headings();
    s_tvalid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pick a point around the calibrated span, reaching a little past it.
  function automatic int pick_near(input int a, input int b);
    int lo, hi, ext;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    ext = (hi - lo) / 4 + 8;
    lo = clip12(lo - ext);
    hi = clip12(hi + ext);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic plan_calibration(input int phase);
    int k, r;
    if (phase == 0) begin
      cal_plan = '{-2048, 2047, -2048, 2047};
    end else if (phase == 1) begin
      cal_plan = '{2047, -2048, 2047, -2048};
    end else begin
      for (k = 0; k < 2; k++) begin
        r = $urandom_range(0, 19);
        cal_plan[2 * k] = rand12();
        if (r == 0) cal_plan[2 * k + 1] = cal_plan[2 * k];
        else if (r < 4) cal_plan[2 * k + 1] = rand12();
        else if (r < 7) cal_plan[2 * k + 1] = clip12(cal_plan[2 * k] - $urandom_range(1, 800));
        else cal_plan[2 * k + 1] = clip12(cal_plan[2 * k] + $urandom_range(1, 800));
      end
      if ($urandom_range(0, 7) == 0)
        cal_plan = '{int'(RST_MIN_X), int'(RST_MAX_X), int'(RST_MIN_Y), int'(RST_MAX_Y)};
    end
  endtask

  // Directed groups: each row holds one sample for a whole group.
  group_row_t dir_rows [13] = '{
    // reset calibration, origin samples
    '{1'b0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0},
    // centered calibration, samples at the center: zero vector gives heading 0
    '{1'b1, -100, 100, -100, 100, 0, 0, 1'b1, 0, 1'b0},
    // both axes saturate positive, then negative (left half plane)
    '{1'b0, 0, 0, 0, 0, 2047, 2047, 1'b0, 0, 1'b0},
    '{1'b0, 0, 0, 0, 0, -2048, -2048, 1'b0, 0, 1'b0},
    '{1'b0, 0, 0, 0, 0, -50, 20, 1'b0, 0, 1'b0},
    '{1'b0, 0, 0, 0, 0, -50, -20, 1'b0, 0, 1'b0},
    '{1'b0, 0, 0, 0, 0, 60, -80, 1'b0, 0, 1'b0},
    // degenerate X range, then degenerate Y range: fault flag, heading 0
    '{1'b1, 5, 5, -100, 100, 2047, -2048, 1'b1, 0, 1'b1},
    '{1'b1, -100, 100, -2048, -2048, -2048, 2047, 1'b1, 0, 1'b1},
    // swapped ranges mirror the axis
    '{1'b1, 100, -100, 2047, -2048, 30, -1000, 1'b0, 0, 1'b0},
    // widest calibration, corner samples
    '{1'b1, -2048, 2047, -2048, 2047, -2048, 2047, 1'b0, 0, 1'b0},
    '{1'b1, 2047, -2048, -2048, 2047, 2047, -2048, 1'b0, 0, 1'b0},
    // back to the reset calibration
    '{1'b1, int'(RST_MIN_X), int'(RST_MAX_X), int'(RST_MIN_Y), int'(RST_MAX_Y),
      2047, -2048, 1'b0, 0, 1'b0}
  };

  initial begin : stimulus
    int           r, n, phase, phase_len, tx, ty, nz, x, y;
    sample_kind_e kind;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    for (r = 0; r < $size(dir_rows); r++) begin
      if (dir_rows[r].do_cal)
        write_calibration(dir_rows[r].lo_x, dir_rows[r].hi_x, dir_rows[r].lo_y,
                          dir_rows[r].hi_y);
      if (dir_rows[r].pinned) begin
        pin_want.cdeg = HEAD_W'(dir_rows[r].cdeg);
        pin_want.err = dir_rows[r].err;
        pin_valid = 1'b1;
      end
      repeat (SAMPLES_PER_HEADING) offer_sample(dir_rows[r].x, dir_rows[r].y);
      drain_headings();
    end

    // Random part: calibration phases, each with a stream of groups aimed at a target.
    n = 0;
    phase = 0;
    tx = 0;
    ty = 0;
    while (n < RANDOM_ITEMS) begin
      plan_calibration(phase);
      write_calibration(cal_plan[0], cal_plan[1], cal_plan[2], cal_plan[3]);
      // Hold the receiver off once so results back up and the input stalls.
      if (phase == 2) hold_req = 1'b1;
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) begin
        if (n % SAMPLES_PER_HEADING == 0) begin
          tx = pick_near(cal_plan[0], cal_plan[1]);
          ty = pick_near(cal_plan[2], cal_plan[3]);
        end
        r = $urandom_range(0, 9);
        kind = (r < 6) ? SMP_NEAR : (r < 8) ? SMP_WIDE : (r == 8) ? SMP_EDGE : SMP_SPAN;
        case (kind)
          SMP_NEAR: begin
            nz = $urandom_range(0, 40);
            x = clip12(tx + int'($urandom_range(0, 2 * nz)) - nz);
            y = clip12(ty + int'($urandom_range(0, 2 * nz)) - nz);
          end
          SMP_WIDE: begin
            x = rand12();
            y = rand12();
          end
          SMP_EDGE: begin
            x = $urandom_range(0, 1) ? 2047 : -2048;
            y = $urandom_range(0, 1) ? 2047 : -2048;
          end
          default: begin
            x = pick_near(cal_plan[0], cal_plan[1]);
            y = pick_near(cal_plan[2], cal_plan[3]);
          end
        endcase
        offer_sample(x, y);
        n++;
      end
      drain_headings();
      phase++;
    end

    drain_headings();
    $display("Covered %0d samples, %0d headings (%0d with calibration fault), %0d calibrations.",
             samples_taken, headings_seen, fault_headings, cal_phases);
    $display("Headings per quadrant: %0d %0d %0d %0d.",
             quad_hits[0], quad_hits[1], quad_hits[2], quad_hits[3]);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Watchdog expired with %0d headings pending", heading_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
